/* rtl/bcpg_pkg.sv */
`timescale 1ns / 1ps

package bcpg_pkg;

   localparam int COORD_W   = 16;
   localparam int STEPS_W   = 7;
   localparam int INDEX_W   = 6;
   localparam int NUM_CTRL  = 4;
   localparam int CTRL_SEL_W = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_PROD,
      ST_WGT,
      ST_MAC,
      ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic                  load;
      logic                  div_step;
      logic                  prod_en;
      logic                  wgt_en;
      logic                  mac_en;
      logic [CTRL_SEL_W-1:0] mac_sel;
      logic                  emit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic zero_steps;
      logic last_point;
      logic out_busy;
   } status_type;

endpackage

/* rtl/bcpg_ctrl.sv */
`timescale 1ns / 1ps

module bcpg_ctrl #(
   parameter int T_FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bcpg_pkg::status_type status,
   output bcpg_pkg::cmd_type    cmd
);

   localparam int DCNT_W = $clog2(T_FRAC_BITS + 1);

   bcpg_pkg::state_type state_ff, state_in;
   logic [DCNT_W-1:0]                 div_cnt_ff, div_cnt_in;
   logic [bcpg_pkg::CTRL_SEL_W-1:0]   mac_k_ff, mac_k_in;

   logic div_done;
   logic mac_done;

   assign div_done = (div_cnt_ff == DCNT_W'(T_FRAC_BITS));
   assign mac_done = (mac_k_ff == bcpg_pkg::CTRL_SEL_W'(bcpg_pkg::NUM_CTRL - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bcpg_pkg::ST_IDLE: begin
            if (req_valid && !status.zero_steps) state_in = bcpg_pkg::ST_DIV;
         end
         bcpg_pkg::ST_DIV: begin
            if (div_done) state_in = bcpg_pkg::ST_PROD;
         end
         bcpg_pkg::ST_PROD: state_in = bcpg_pkg::ST_WGT;
         bcpg_pkg::ST_WGT:  state_in = bcpg_pkg::ST_MAC;
         bcpg_pkg::ST_MAC: begin
            if (mac_done) state_in = bcpg_pkg::ST_EMIT;
         end
         bcpg_pkg::ST_EMIT: begin
            if (!status.out_busy) begin
               state_in = status.last_point ? bcpg_pkg::ST_IDLE : bcpg_pkg::ST_PROD;
            end
         end
         default: state_in = bcpg_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.mac_sel  = mac_k_ff;
      case (state_ff)
         bcpg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         bcpg_pkg::ST_DIV:  cmd.div_step = 1'b1;
         bcpg_pkg::ST_PROD: cmd.prod_en  = 1'b1;
         bcpg_pkg::ST_WGT:  cmd.wgt_en   = 1'b1;
         bcpg_pkg::ST_MAC:  cmd.mac_en   = 1'b1;
         bcpg_pkg::ST_EMIT: cmd.emit     = !status.out_busy;
         default: ;
      endcase
   end

   // step counters
   always_comb begin
      div_cnt_in = div_cnt_ff;
      mac_k_in   = mac_k_ff;
      if (state_ff == bcpg_pkg::ST_IDLE) div_cnt_in = '0;
      else if (state_ff == bcpg_pkg::ST_DIV) div_cnt_in = div_cnt_ff + DCNT_W'(1);
      if (state_ff == bcpg_pkg::ST_MAC) mac_k_in = mac_k_ff + bcpg_pkg::CTRL_SEL_W'(1);
      else mac_k_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bcpg_pkg::ST_IDLE;
         div_cnt_ff <= '0;
         mac_k_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
         mac_k_ff   <= mac_k_in;
      end
   end

endmodule

/* rtl/bcpg_datapath.sv */
`timescale 1ns / 1ps

module bcpg_datapath #(
   parameter int MAX_STEPS   = 64,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic signed [bcpg_pkg::COORD_W-1:0]   req_p0_x,
   input  logic signed [bcpg_pkg::COORD_W-1:0]   req_p0_y,
   input  logic signed [bcpg_pkg::COORD_W-1:0]   req_p1_x,
   input  logic signed [bcpg_pkg::COORD_W-1:0]   req_p1_y,
   input  logic signed [bcpg_pkg::COORD_W-1:0]   req_p2_x,
   input  logic signed [bcpg_pkg::COORD_W-1:0]   req_p2_y,
   input  logic signed [bcpg_pkg::COORD_W-1:0]   req_p3_x,
   input  logic signed [bcpg_pkg::COORD_W-1:0]   req_p3_y,
   input  logic        [bcpg_pkg::STEPS_W-1:0]   req_steps,
   input  bcpg_pkg::cmd_type                     cmd,
   output bcpg_pkg::status_type                  status,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [bcpg_pkg::COORD_W-1:0]   rsp_out_x,
   output logic signed [bcpg_pkg::COORD_W-1:0]   rsp_out_y,
   output logic        [bcpg_pkg::INDEX_W-1:0]   rsp_point_index,
   output logic                                  rsp_last
);

   localparam int M_W    = $clog2(MAX_STEPS + 1);
   localparam int J_W    = $clog2(MAX_STEPS);
   localparam int TW     = T_FRAC_BITS + 1;          // t, u and 2^F
   localparam int SQ_W   = 2 * TW;
   localparam int CU_W   = 3 * TW;
   localparam int W_W    = 3 * T_FRAC_BITS + 1;      // weights, at most 2^(3F)
   localparam int PROD_W = W_W + 1 + bcpg_pkg::COORD_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int SHIFT  = 3 * T_FRAC_BITS;
   localparam logic [TW-1:0]    ONE  = {1'b1, {T_FRAC_BITS{1'b0}}};
   localparam logic [ACC_W-1:0] HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (SHIFT - 1);

   // request
   logic signed [bcpg_pkg::COORD_W-1:0] px_ff [bcpg_pkg::NUM_CTRL];
   logic signed [bcpg_pkg::COORD_W-1:0] py_ff [bcpg_pkg::NUM_CTRL];
   logic [M_W-1:0] m_ff;

   // divider: dq = 2^F / m, dr = 2^F mod m
   logic [TW-1:0]  dq_ff;
   logic [M_W-1:0] dr_ff;
   logic [M_W:0]   div_rem_sh;
   logic           div_bit;

   // parameter walk
   logic [TW-1:0]  t_ff;
   logic [M_W-1:0] r_ff;
   logic [J_W-1:0] j_ff;
   logic [M_W:0]   r_sum;
   logic           r_carry;

   // weights
   logic [TW-1:0]   u_ff;
   logic [SQ_W-1:0] tt_ff, tu_ff, uu_ff;
   logic [W_W-1:0]  w_ff [bcpg_pkg::NUM_CTRL];
   logic [CU_W-1:0] w0_raw, w1_raw, w2_raw, w3_raw;

   // accumulate
   logic signed [PROD_W-1:0] prod_x, prod_y;
   logic signed [ACC_W-1:0]  acc_x_ff, acc_y_ff;
   logic signed [ACC_W-1:0]  acc_x_base, acc_y_base;
   logic signed [ACC_W-1:0]  sum_x, sum_y;
   logic [W_W-1:0]           w_sel;

   // output register
   logic                                rsp_valid_ff;
   logic signed [bcpg_pkg::COORD_W-1:0] out_x_ff, out_y_ff;
   logic [bcpg_pkg::INDEX_W-1:0]        idx_ff;
   logic                                last_ff;

   logic [bcpg_pkg::STEPS_W-1:0] steps_sat;

   assign steps_sat = (req_steps > bcpg_pkg::STEPS_W'(MAX_STEPS)) ?
                      bcpg_pkg::STEPS_W'(MAX_STEPS) : req_steps;

   // restoring divide, one quotient bit a cycle; dq_ff starts as the dividend
   assign div_rem_sh = {dr_ff, dq_ff[TW-1]};
   assign div_bit    = (div_rem_sh >= {1'b0, m_ff});

   // t += dq, plus a carry when the fraction remainder wraps m
   assign r_sum   = {1'b0, r_ff} + {1'b0, dr_ff};
   assign r_carry = (r_sum >= {1'b0, m_ff});

   assign w0_raw = uu_ff * u_ff;
   assign w1_raw = tu_ff * u_ff;
   assign w2_raw = tu_ff * t_ff;
   assign w3_raw = tt_ff * t_ff;

   assign w_sel  = w_ff[cmd.mac_sel];
   assign prod_x = $signed({1'b0, w_sel}) * px_ff[cmd.mac_sel];
   assign prod_y = $signed({1'b0, w_sel}) * py_ff[cmd.mac_sel];

   assign acc_x_base = (cmd.mac_sel == '0) ? '0 : acc_x_ff;
   assign acc_y_base = (cmd.mac_sel == '0) ? '0 : acc_y_ff;

   // round half up, then arithmetic shift by 3F
   assign sum_x = acc_x_ff + $signed(HALF);
   assign sum_y = acc_y_ff + $signed(HALF);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff[0] <= req_p0_x;
         py_ff[0] <= req_p0_y;
         px_ff[1] <= req_p1_x;
         py_ff[1] <= req_p1_y;
         px_ff[2] <= req_p2_x;
         py_ff[2] <= req_p2_y;
         px_ff[3] <= req_p3_x;
         py_ff[3] <= req_p3_y;
         m_ff     <= M_W'(steps_sat);
         dq_ff    <= ONE;
         dr_ff    <= '0;
         t_ff     <= '0;
         r_ff     <= '0;
         j_ff     <= '0;
      end else if (cmd.div_step) begin
         dq_ff <= {dq_ff[TW-2:0], div_bit};
         dr_ff <= div_bit ? M_W'(div_rem_sh - {1'b0, m_ff}) : M_W'(div_rem_sh);
      end else if (cmd.emit) begin
         t_ff <= t_ff + dq_ff + TW'(r_carry);
         r_ff <= r_carry ? M_W'(r_sum - {1'b0, m_ff}) : M_W'(r_sum);
         j_ff <= j_ff + J_W'(1);
      end

      if (cmd.prod_en) begin
         u_ff  <= ONE - t_ff;
         tt_ff <= t_ff * t_ff;
         tu_ff <= t_ff * (ONE - t_ff);
         uu_ff <= (ONE - t_ff) * (ONE - t_ff);
      end

      if (cmd.wgt_en) begin
         w_ff[0] <= W_W'(w0_raw);
         w_ff[1] <= W_W'(w1_raw) + (W_W'(w1_raw) << 1);
         w_ff[2] <= W_W'(w2_raw) + (W_W'(w2_raw) << 1);
         w_ff[3] <= W_W'(w3_raw);
      end

      if (cmd.mac_en) begin
         acc_x_ff <= acc_x_base + ACC_W'(prod_x);
         acc_y_ff <= acc_y_base + ACC_W'(prod_y);
      end

      if (cmd.emit) begin
         out_x_ff <= sum_x[SHIFT +: bcpg_pkg::COORD_W];
         out_y_ff <= sum_y[SHIFT +: bcpg_pkg::COORD_W];
         idx_ff   <= bcpg_pkg::INDEX_W'(j_ff);
         last_ff  <= status.last_point;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.zero_steps = (req_steps == '0);
   assign status.last_point = (M_W'(j_ff) == m_ff - M_W'(1));
   assign status.out_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = out_x_ff;
   assign rsp_out_y       = out_y_ff;
   assign rsp_point_index = idx_ff;
   assign rsp_last        = last_ff;

endmodule

/* rtl/bezier_curve_point_generator.sv */
`timescale 1ns / 1ps
// Cubic Bezier point generator.
// req_ channel: one transaction carries control points P0..P3 and a step count m.
// rsp_ channel: m transactions come back, point j at t = j/m, j = 0..m-1, with
// rsp_last high on the final one. m = 0 is accepted and produces nothing;
// m above MAX_STEPS is clipped to MAX_STEPS.
// Operation: a request first runs a restoring divide of 2^T_FRAC_BITS by m,
// one quotient bit a cycle. Each point then runs through the t*t/t*u/u*u
// products, the weight cubes, four multiply-accumulate steps (one control
// point each, x and y in parallel) and the emit step.
// One request is worked on at a time: req_ready is high only when idle.
// The result sits in an output register, so the next point is computed
// while the receiver stalls; only the emit step waits for rsp_ready.
// Reset (synchronous, active high) returns the controller to idle and
// drops rsp_valid; nothing else needs clearing.

module bezier_curve_point_generator #(
   parameter int MAX_STEPS   = 64,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [bcpg_pkg::COORD_W-1:0] req_p0_x,
   input  logic signed [bcpg_pkg::COORD_W-1:0] req_p0_y,
   input  logic signed [bcpg_pkg::COORD_W-1:0] req_p1_x,
   input  logic signed [bcpg_pkg::COORD_W-1:0] req_p1_y,
   input  logic signed [bcpg_pkg::COORD_W-1:0] req_p2_x,
   input  logic signed [bcpg_pkg::COORD_W-1:0] req_p2_y,
   input  logic signed [bcpg_pkg::COORD_W-1:0] req_p3_x,
   input  logic signed [bcpg_pkg::COORD_W-1:0] req_p3_y,
   input  logic        [bcpg_pkg::STEPS_W-1:0] req_steps,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [bcpg_pkg::COORD_W-1:0] rsp_out_x,
   output logic signed [bcpg_pkg::COORD_W-1:0] rsp_out_y,
   output logic        [bcpg_pkg::INDEX_W-1:0] rsp_point_index,
   output logic                                rsp_last
);

   bcpg_pkg::cmd_type    cmd;
   bcpg_pkg::status_type status;

   // sequencer: divide, then per point products/weights/MAC/emit
   bcpg_ctrl #(
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and the output register
   bcpg_datapath #(
      .MAX_STEPS   (MAX_STEPS),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_p0_x        (req_p0_x),
      .req_p0_y        (req_p0_y),
      .req_p1_x        (req_p1_x),
      .req_p1_y        (req_p1_y),
      .req_p2_x        (req_p2_x),
      .req_p2_y        (req_p2_y),
      .req_p3_x        (req_p3_x),
      .req_p3_y        (req_p3_y),
      .req_steps       (req_steps),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_point_index (rsp_point_index),
      .rsp_last        (rsp_last)
   );

endmodule

/* tb/tb_bezier_curve_point_generator.sv */
`timescale 1ns / 1ps

module tb_bezier_curve_point_generator;

   localparam int MAX_STEPS   = 64;
   localparam int T_FRAC_BITS = 16;
   localparam int WGT_SHIFT   = 3 * T_FRAC_BITS;   // weights sum to 2^48
   localparam int RANDOM_REQS = 245;
   localparam int CALM_FIRST  = 120;               // random items run with no idling
   localparam int CALM_LAST   = 170;
   localparam int DRAIN_WAIT  = 64;                // covers a trailing zero-step request
   localparam int REPORT_MAX  = 10;
   localparam int LIMIT       = 1_000_000;

   // One request transaction: four control points and a step count.
   typedef struct {
      logic signed [bcpg_pkg::COORD_W-1:0] cx [bcpg_pkg::NUM_CTRL];
      logic signed [bcpg_pkg::COORD_W-1:0] cy [bcpg_pkg::NUM_CTRL];
      logic        [bcpg_pkg::STEPS_W-1:0] steps;
   } curve_req_type;

   // One response transaction: a single point on the curve.
   typedef struct packed {
      logic signed [bcpg_pkg::COORD_W-1:0] x;
      logic signed [bcpg_pkg::COORD_W-1:0] y;
      logic        [bcpg_pkg::INDEX_W-1:0] index;
      logic                                last;
   } curve_point_type;

   // Expected curve points, predicted per accepted request and consumed in order.
   class curve_scoreboard;
      curve_point_type pending_points[$];
      int unsigned     mismatches;
      int unsigned     points_checked;
      int unsigned     requests_seen;

      // Rounded Bernstein blend of one coordinate: sum(w*P) + 2^47, then >>> 48.
      function logic signed [bcpg_pkg::COORD_W-1:0] blend(
            input logic [63:0] w [bcpg_pkg::NUM_CTRL],
            input logic signed [bcpg_pkg::COORD_W-1:0] c [bcpg_pkg::NUM_CTRL]);
         logic signed [79:0] acc;
         logic signed [79:0] wide_w;
         logic signed [79:0] wide_c;
         acc = '0;
         for (int k = 0; k < bcpg_pkg::NUM_CTRL; k++) begin
            wide_w = {16'h0, w[k]};
            wide_c = c[k];
            acc    = acc + wide_w * wide_c;
         end
         acc = acc + (80'sd1 <<< (WGT_SHIFT - 1));
         acc = acc >>> WGT_SHIFT;
         return acc[bcpg_pkg::COORD_W-1:0];
      endfunction

      function void note_request(input curve_req_type r);
         logic [63:0]     m;
         logic [63:0]     t;
         logic [63:0]     u;
         logic [63:0]     w [bcpg_pkg::NUM_CTRL];
         curve_point_type p;
         requests_seen++;
         m = r.steps;
         if (m > MAX_STEPS) m = MAX_STEPS;      // saturates, zero gives nothing
         for (int j = 0; j < m; j++) begin
            t    = (64'(j) << T_FRAC_BITS) / m;
            u    = (64'd1 << T_FRAC_BITS) - t;
            w[0] = u * u * u;
            w[1] = 3 * t * u * u;
            w[2] = 3 * t * t * u;
            w[3] = t * t * t;
            p.x     = blend(w, r.cx);
            p.y     = blend(w, r.cy);
            p.index = j[bcpg_pkg::INDEX_W-1:0];
            p.last  = (j == m - 1);
            pending_points.push_back(p);
         end
      endfunction

      function void check_point(input curve_point_type got);
         curve_point_type exp_pt;
         if (pending_points.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected point: x=%0d y=%0d idx=%0d last=%0b",
                        got.x, got.y, got.index, got.last);
            return;
         end
         exp_pt = pending_points.pop_front();
         points_checked++;
         if (got.x !== exp_pt.x || got.y !== exp_pt.y ||
             got.index !== exp_pt.index || got.last !== exp_pt.last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display({"point mismatch: exp x=%0d y=%0d idx=%0d last=%0b, ",
                         "got x=%0d y=%0d idx=%0d last=%0b"},
                        exp_pt.x, exp_pt.y, exp_pt.index, exp_pt.last,
                        got.x, got.y, got.index, got.last);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic signed [bcpg_pkg::COORD_W-1:0] req_p0_x = '0;
   logic signed [bcpg_pkg::COORD_W-1:0] req_p0_y = '0;
   logic signed [bcpg_pkg::COORD_W-1:0] req_p1_x = '0;
   logic signed [bcpg_pkg::COORD_W-1:0] req_p1_y = '0;
   logic signed [bcpg_pkg::COORD_W-1:0] req_p2_x = '0;
   logic signed [bcpg_pkg::COORD_W-1:0] req_p2_y = '0;
   logic signed [bcpg_pkg::COORD_W-1:0] req_p3_x = '0;
   logic signed [bcpg_pkg::COORD_W-1:0] req_p3_y = '0;
   logic        [bcpg_pkg::STEPS_W-1:0] req_steps = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [bcpg_pkg::COORD_W-1:0] rsp_out_x;
   logic signed [bcpg_pkg::COORD_W-1:0] rsp_out_y;
   logic        [bcpg_pkg::INDEX_W-1:0] rsp_point_index;
   logic                                rsp_last;

   logic calm = 1'b0;           // high: neither side idles
   int unsigned cycles = 0;

   curve_scoreboard sb = new();
   curve_req_type   stimulus[$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   bezier_curve_point_generator #(
      .MAX_STEPS   (MAX_STEPS),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_p0_x        (req_p0_x),
      .req_p0_y        (req_p0_y),
      .req_p1_x        (req_p1_x),
      .req_p1_y        (req_p1_y),
      .req_p2_x        (req_p2_x),
      .req_p2_y        (req_p2_y),
      .req_p3_x        (req_p3_x),
      .req_p3_y        (req_p3_y),
      .req_steps       (req_steps),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_point_index (rsp_point_index),
      .rsp_last        (rsp_last)
   );

   // Receiver backpressure: about 22% stall, none during the calm stretch.
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 22);
   end

   // Monitor: every transaction is taken at the rising edge where valid and
   // ready are both high. Requests feed the predictor, responses get checked.
   always @(posedge clock) begin
      curve_req_type   seen;
      curve_point_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            seen.cx[0] = req_p0_x;  seen.cy[0] = req_p0_y;
            seen.cx[1] = req_p1_x;  seen.cy[1] = req_p1_y;
            seen.cx[2] = req_p2_x;  seen.cy[2] = req_p2_y;
            seen.cx[3] = req_p3_x;  seen.cy[3] = req_p3_y;
            seen.steps = req_steps;
            sb.note_request(seen);
         end
         if (rsp_valid && rsp_ready) begin
            got.x     = rsp_out_x;
            got.y     = rsp_out_y;
            got.index = rsp_point_index;
            got.last  = rsp_last;
            sb.check_point(got);
         end
      end
   end

   // Watchdog: a hang or a lost response ends the run here.
   initial begin
      while (cycles < LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d points still pending",
               cycles, sb.pending_points.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic curve_req_type make_req(input int x0, input int y0,
                                              input int x1, input int y1,
                                              input int x2, input int y2,
                                              input int x3, input int y3,
                                              input int steps);
      curve_req_type r;
      r.cx[0] = x0[bcpg_pkg::COORD_W-1:0];  r.cy[0] = y0[bcpg_pkg::COORD_W-1:0];
      r.cx[1] = x1[bcpg_pkg::COORD_W-1:0];  r.cy[1] = y1[bcpg_pkg::COORD_W-1:0];
      r.cx[2] = x2[bcpg_pkg::COORD_W-1:0];  r.cy[2] = y2[bcpg_pkg::COORD_W-1:0];
      r.cx[3] = x3[bcpg_pkg::COORD_W-1:0];  r.cy[3] = y3[bcpg_pkg::COORD_W-1:0];
      r.steps = steps[bcpg_pkg::STEPS_W-1:0];
      return r;
   endfunction

   // Coordinates lean toward the extremes and the sign boundary.
   function automatic int rand_coord();
      case ($urandom_range(9))
         0:       return -32768;
         1:       return 32767;
         2:       return 0;
         3:       return -1;
         default: return $signed($urandom_range(65535) - 32768);
      endcase
   endfunction

   // Mostly legal step counts; some zero and some past the saturation point.
   function automatic int rand_steps();
      int roll;
      roll = $urandom_range(99);
      if (roll < 4)  return 0;
      if (roll < 12) return $urandom_range(127, MAX_STEPS + 1);
      if (roll < 30) return $urandom_range(8, 1);
      return $urandom_range(MAX_STEPS, 1);
   endfunction

   // Sender: called at a falling edge, returns at the falling edge after
   // acceptance. Valid stays up with a stable payload until taken.
   task automatic send_request(input curve_req_type r);
      while (!calm && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_p0_x  <= r.cx[0];  req_p0_y <= r.cy[0];
      req_p1_x  <= r.cx[1];  req_p1_y <= r.cy[1];
      req_p2_x  <= r.cx[2];  req_p2_y <= r.cy[2];
      req_p3_x  <= r.cx[3];  req_p3_y <= r.cy[3];
      req_steps <= r.steps;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      // directed: extremes, degenerate curves, zero and saturated step counts
      stimulus.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0, 1));
      stimulus.push_back(make_req(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 64));
      stimulus.push_back(make_req(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                                  64));
      stimulus.push_back(make_req(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768, 2));
      stimulus.push_back(make_req(32767, -32768, -32768, 32767, 32767, -32768, -32768, 32767, 3));
      stimulus.push_back(make_req(1234, -5678, 100, 200, -300, 400, 5000, -6000, 0));
      stimulus.push_back(make_req(-1000, 1000, 20000, -20000, -20000, 20000, 1000, -1000, 65));
      stimulus.push_back(make_req(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 127));
      stimulus.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0));
      stimulus.push_back(make_req(10, -10, -20, 20, 30, -30, -40, 40, 100));
      stimulus.push_back(make_req(1, -1, -1, 1, 1, -1, -1, 1, 5));    // rounding near zero
      stimulus.push_back(make_req(0, 1, 0, 1, 1, 0, 1, 0, 7));
      stimulus.push_back(make_req(-32768, 0, 0, -32768, 32767, 0, 0, 32767, 13));
      stimulus.push_back(make_req(21845, -21846, -10923, 10922, 5461, -5462, -1, 0, 63));
      stimulus.push_back(make_req(32767, -32768, 0, 0, 0, 0, -32768, 32767, 1));
      for (int i = 0; i < RANDOM_REQS; i++)
         stimulus.push_back(make_req(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                     rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                     rand_steps()));

      // reset: held from the start, released on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (stimulus[i]) begin
         calm <= (i >= CALM_FIRST && i < CALM_LAST);
         send_request(stimulus[i]);
      end
      req_valid <= 1'b0;
      calm      <= 1'b0;

      // drain, then give a trailing zero-step request time to misbehave
      while (sb.pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("ran %0d curve requests (zero, saturated, full-range steps), %0d points checked",
               sb.requests_seen, sb.points_checked);
      $display("mismatches %0d, points left unmatched %0d, cycles %0d",
               sb.mismatches, sb.pending_points.size(), cycles);
      if (sb.mismatches == 0 && sb.pending_points.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
